// ===== rtl/c2dmc_pkg.sv =====
package c2dmc_pkg;

  // structural limits
  localparam int MaxInCh  = 4;
  localparam int MaxOutCh = 8;
  localparam int MaxDim   = 32;
  localparam int MaxK     = 5;

  localparam int SampleDepth = MaxInCh * MaxDim * MaxDim;
  localparam int WeightDepth = MaxOutCh * MaxInCh * MaxK * MaxK;
  localparam int BiasDepth   = MaxOutCh * MaxDim * MaxDim;

  localparam int SampleAw = $clog2(SampleDepth);
  localparam int WeightAw = $clog2(WeightDepth);
  localparam int BiasAw   = $clog2(BiasDepth);

  localparam int IdxW  = 13;
  localparam int ValW  = 16;
  localparam int AccW  = 40;
  localparam int DataW = 32;

  // request kinds
  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_WEIGHT  = 2'd1,
    REQ_BIAS    = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_IN_DEPTH  = 3'd0,
    CFG_IN_HEIGHT = 3'd1,
    CFG_IN_WIDTH  = 3'd2,
    CFG_KSIZE     = 3'd3,
    CFG_OUT_DEPTH = 3'd4,
    CFG_RSVD5     = 3'd5,
    CFG_RSVD6     = 3'd6,
    CFG_RSVD7     = 3'd7
  } cfg_e;

endpackage

// ===== rtl/conv2d_multichannel_valid.sv =====
// channel   | direction | tdata (low bit up)           | tuser
// s_axis    | in        | index[12:0], value[28:13]    | req_type[1:0]
// m_axis    | out       | out_index[12:0], out_value[28:13] | status[1:0]
// cfg       | in        | cfg_addr_i register index, cfg_data_i low bits kept
//
// one item at a time: a load passes S_PREP1, S_PREP2, S_PREP3 and S_CHECK, plus S_OUT
// when it reports a range error; a compute goes on through the two 13-step
// shift-subtract divisions that split the flat index and the single-port
// MAC loop over the sample and weight memories (one tap issued per cycle)
// a result may wait in the output register while the next item is accepted;
// a second result stalls in S_OUT until that register is taken
// stores are not cleared at reset; configuration returns to its reset values
module conv2d_multichannel_valid
  import c2dmc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // index[12:0], value[28:13]
  input  logic [1:0]       s_axis_tuser_i,   // req_type[1:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // out_index[12:0], out_value[28:13]
  output logic [1:0]       m_axis_tuser_o,   // status[1:0]
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_addr_i,
  input  logic [7:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP1, S_PREP2, S_PREP3, S_CHECK, S_DIV1, S_DIV2,
    S_BASE, S_BIAS, S_MAC, S_ROUND, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [2:0] depth_q;
  logic [5:0] height_q, width_q;
  logic [2:0] ksz_q;
  logic [3:0] odepth_q;

  // item
  req_e                   req_q;
  logic [IdxW-1:0]        idx_q;
  logic signed [ValW-1:0] val_q;

  // sizes derived per item
  logic [10:0] plane_q, hw_q;
  logic [4:0]  kk_q;
  logic [13:0] nout_q;
  logic [12:0] dhw_q;
  logic [6:0]  dkk_q;
  logic [9:0]  wlim_q;

  // divider
  logic [12:0] num_q;
  logic [10:0] rem_q, divisor_q;
  logic [3:0]  div_cnt_q;
  logic [2:0]  o_q;
  logic [4:0]  r_q;

  // mac loop
  logic [12:0] sptr_q, row_q, chan_q;
  logic [9:0]  wptr_q;
  logic [2:0]  i_q, j_q;
  logic [6:0]  iss_q;
  logic        v1_q, v2_q;
  logic signed [31:0]     prod_q;
  logic signed [AccW-1:0] acc_q;

  // memories
  logic signed [ValW-1:0] sample_mem [SampleDepth];
  logic signed [ValW-1:0] weight_mem [WeightDepth];
  logic signed [ValW-1:0] bias_mem   [BiasDepth];
  logic signed [ValW-1:0] s_rd_q, w_rd_q, b_rd_q;
  logic smp_we, wgt_we, bia_we;

  // result and output register
  logic [ValW-1:0] res_val_q;
  status_e         res_st_q;
  logic            m_valid_q;
  logic [IdxW-1:0] m_idx_q;
  logic [ValW-1:0] m_val_q;
  status_e         m_st_q;

  // clamped configuration
  logic [2:0] d_c, k_c;
  logic [5:0] h_c, w_c, oh_c, ow_c;
  logic [3:0] o_c;

  always_comb begin
    d_c = (depth_q == 3'd0) ? 3'd1 : (depth_q > 3'(MaxInCh)) ? 3'(MaxInCh) : depth_q;
    h_c = (height_q == 6'd0) ? 6'd1 : (height_q > 6'(MaxDim)) ? 6'(MaxDim) : height_q;
    w_c = (width_q == 6'd0) ? 6'd1 : (width_q > 6'(MaxDim)) ? 6'(MaxDim) : width_q;
    k_c = (ksz_q == 3'd0) ? 3'd1 : (ksz_q > 3'(MaxK)) ? 3'(MaxK) : ksz_q;
    o_c = (odepth_q == 4'd0) ? 4'd1 : (odepth_q > 4'(MaxOutCh)) ? 4'(MaxOutCh) : odepth_q;
    oh_c = (h_c >= {3'b0, k_c}) ? 6'(h_c - {3'b0, k_c} + 6'd1) : 6'd0;
    ow_c = (w_c >= {3'b0, k_c}) ? 6'(w_c - {3'b0, k_c} + 6'd1) : 6'd0;
  end

  // range checks against the selected tensor
  logic smp_ok, wgt_ok, out_ok;
  assign smp_ok = ({1'b0, idx_q} < {1'b0, dhw_q}) && ({1'b0, idx_q} < 14'(SampleDepth));
  assign wgt_ok = ({1'b0, idx_q} < {4'b0, wlim_q}) && ({1'b0, idx_q} < 14'(WeightDepth));
  assign out_ok = ({1'b0, idx_q} < nout_q) && ({1'b0, idx_q} < 14'(BiasDepth));

  assign smp_we = (state_q == S_CHECK) && (req_q == REQ_SAMPLE) && smp_ok;
  assign wgt_we = (state_q == S_CHECK) && (req_q == REQ_WEIGHT) && wgt_ok;
  assign bia_we = (state_q == S_CHECK) && (req_q == REQ_BIAS) && out_ok;

  // shift-subtract step
  logic [11:0] trial;
  logic        ge;
  logic [10:0] rem_nx;
  assign trial  = {rem_q, num_q[12]};
  assign ge     = trial >= {1'b0, divisor_q};
  assign rem_nx = ge ? 11'(trial - {1'b0, divisor_q}) : trial[10:0];

  // rounding and saturation
  logic signed [AccW-1:0] sum_r, q_r;
  assign sum_r = acc_q + AccW'(2048);
  assign q_r   = sum_r >>> 12;

  logic last_tap_j, last_tap_i;
  assign last_tap_j = (j_q == k_c - 3'd1);
  assign last_tap_i = (i_q == k_c - 3'd1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b0, m_val_q, m_idx_q};
  assign m_axis_tuser_o  = m_st_q;

  // storage, read every cycle into registered outputs
  always_ff @(posedge clk_i) begin
    if (smp_we) sample_mem[idx_q[SampleAw-1:0]] <= val_q;
    if (wgt_we) weight_mem[idx_q[WeightAw-1:0]] <= val_q;
    if (bia_we) bias_mem[idx_q[BiasAw-1:0]] <= val_q;
    s_rd_q <= sample_mem[sptr_q[SampleAw-1:0]];
    w_rd_q <= weight_mem[wptr_q[WeightAw-1:0]];
    b_rd_q <= bias_mem[idx_q[BiasAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= 3'd1;
      height_q  <= 6'd32;
      width_q   <= 6'd32;
      ksz_q     <= 3'd3;
      odepth_q  <= 4'd1;
      m_valid_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      req_q     <= REQ_SAMPLE;
      res_st_q  <= ST_OK;
      m_st_q    <= ST_OK;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_addr_i))
          CFG_IN_DEPTH:  depth_q  <= cfg_data_i[2:0];
          CFG_IN_HEIGHT: height_q <= cfg_data_i[5:0];
          CFG_IN_WIDTH:  width_q  <= cfg_data_i[5:0];
          CFG_KSIZE:     ksz_q    <= cfg_data_i[2:0];
          CFG_OUT_DEPTH: odepth_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end

      // output register: load a new result or hand the held one over
      if ((state_q == S_OUT) && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      // mac pipeline: read data -> product -> accumulate
      v1_q   <= (state_q == S_MAC) && (iss_q != dkk_q);
      v2_q   <= v1_q;
      prod_q <= s_rd_q * w_rd_q;
      if (v2_q) acc_q <= acc_q + AccW'(prod_q);

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            req_q   <= req_e'(s_axis_tuser_i);
            idx_q   <= s_axis_tdata_i[IdxW-1:0];
            val_q   <= s_axis_tdata_i[IdxW+ValW-1:IdxW];
            state_q <= S_PREP1;
          end
        end
        S_PREP1: begin
          plane_q <= {5'b0, oh_c} * {5'b0, ow_c};
          hw_q    <= {5'b0, h_c} * {5'b0, w_c};
          kk_q    <= {2'b0, k_c} * {2'b0, k_c};
          state_q <= S_PREP2;
        end
        S_PREP2: begin
          nout_q  <= 14'({10'b0, o_c} * {3'b0, plane_q});
          dhw_q   <= 13'({10'b0, d_c} * {2'b0, hw_q});
          dkk_q   <= 7'({4'b0, d_c} * {2'b0, kk_q});
          state_q <= S_PREP3;
        end
        S_PREP3: begin
          wlim_q  <= 10'({6'b0, o_c} * {3'b0, dkk_q});
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          res_val_q <= '0;
          res_st_q  <= ST_RANGE;
          unique case (req_q)
            REQ_SAMPLE:  state_q <= smp_ok ? S_IDLE : S_OUT;
            REQ_WEIGHT:  state_q <= wgt_ok ? S_IDLE : S_OUT;
            REQ_BIAS:    state_q <= out_ok ? S_IDLE : S_OUT;
            REQ_COMPUTE: begin
              if (out_ok) begin
                num_q     <= idx_q;
                rem_q     <= '0;
                divisor_q <= plane_q;
                div_cnt_q <= '0;
                state_q   <= S_DIV1;
              end else begin
                state_q <= S_OUT;
              end
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_DIV1, S_DIV2: begin
          if (div_cnt_q != 4'(IdxW - 1)) begin
            num_q     <= {num_q[11:0], ge};
            rem_q     <= rem_nx;
            div_cnt_q <= div_cnt_q + 4'd1;
          end else if (state_q == S_DIV1) begin
            // output channel known, now split the in-plane remainder
            o_q       <= {num_q[1:0], ge};
            num_q     <= {2'b0, rem_nx};
            rem_q     <= '0;
            divisor_q <= {5'b0, ow_c};
            div_cnt_q <= '0;
            state_q   <= S_DIV2;
          end else begin
            rem_q   <= rem_nx;
            r_q     <= {num_q[3:0], ge};
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          // c is the final remainder
          wptr_q  <= 10'({7'b0, o_q} * {3'b0, dkk_q});
          row_q   <= 13'({8'b0, r_q} * {7'b0, w_c}) + {2'b0, rem_q};
          chan_q  <= 13'({8'b0, r_q} * {7'b0, w_c}) + {2'b0, rem_q};
          sptr_q  <= 13'({8'b0, r_q} * {7'b0, w_c}) + {2'b0, rem_q};
          i_q     <= '0;
          j_q     <= '0;
          iss_q   <= '0;
          state_q <= S_BIAS;
        end
        S_BIAS: begin
          acc_q   <= AccW'(b_rd_q) <<< 12;
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (iss_q != dkk_q) begin
            iss_q  <= iss_q + 7'd1;
            wptr_q <= wptr_q + 10'd1;
            if (last_tap_j) begin
              j_q <= '0;
              if (last_tap_i) begin
                i_q    <= '0;
                chan_q <= chan_q + {2'b0, hw_q};
                row_q  <= chan_q + {2'b0, hw_q};
                sptr_q <= chan_q + {2'b0, hw_q};
              end else begin
                i_q    <= i_q + 3'd1;
                row_q  <= row_q + {7'b0, w_c};
                sptr_q <= row_q + {7'b0, w_c};
              end
            end else begin
              j_q    <= j_q + 3'd1;
              sptr_q <= sptr_q + 13'd1;
            end
          end else if (!v1_q && !v2_q) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (q_r > AccW'(32767)) begin
            res_val_q <= 16'h7FFF;
            res_st_q  <= ST_SAT;
          end else if (q_r < -AccW'(32768)) begin
            res_val_q <= 16'h8000;
            res_st_q  <= ST_SAT;
          end else begin
            res_val_q <= q_r[ValW-1:0];
            res_st_q  <= ST_OK;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_idx_q   <= idx_q;
            m_val_q   <= res_val_q;
            m_st_q    <= res_st_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an out-of-range result always carries a zero value
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_st_q == ST_RANGE) |-> (m_val_q == '0))
    else $error("range error with non-zero value");

  // saturation is reported only at a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_st_q == ST_SAT) |-> (m_val_q == 16'h7FFF || m_val_q == 16'h8000))
    else $error("saturated result not at a bound");

  // the tap counter never passes the window size
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (iss_q <= dkk_q))
    else $error("mac issue count overran");

  // an accepted item leaves the idle state
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> (state_q == S_PREP1))
    else $error("accepted item not started");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import c2dmc_pkg::*;

  localparam int WatchLimit = 20000;  // cycles without any handshake
  localparam int SettleCyc  = 200;    // longer than one compute plus the output slot

  typedef enum int {V_RAND, V_MAX, V_MIN, V_ZERO} vsel_e;

  typedef struct {
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] val;
    status_e                st;
  } conv_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i = '0;   // index[12:0], value[28:13]
  logic [1:0]       s_axis_tuser_i = '0;   // req_type[1:0]
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DataW-1:0] m_axis_tdata_o;        // out_index[12:0], out_value[28:13]
  logic [1:0]       m_axis_tuser_o;        // status[1:0]
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_addr_i = '0;
  logic [7:0]       cfg_data_i = '0;

  conv2d_multichannel_valid dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow copy of the layer: registers, stores and which entries hold data
  logic [2:0] r_depth = 3'd1;
  logic [5:0] r_height = 6'd32;
  logic [5:0] r_width = 6'd32;
  logic [2:0] r_ksize = 3'd3;
  logic [3:0] r_odepth = 4'd1;
  int g_d, g_h, g_w, g_k, g_o, g_oh, g_ow, n_out;

  logic signed [ValW-1:0] sample_mem [SampleDepth];
  logic signed [ValW-1:0] weight_mem [WeightDepth];
  logic signed [ValW-1:0] bias_mem [BiasDepth];
  bit sample_wr [SampleDepth];
  bit weight_wr [WeightDepth];
  bit bias_wr [BiasDepth];

  conv_res_t pending_res[$];
  int        errors = 0;
  int        idle_cyc = 0;
  int        gap_mode = 0;      // 0 none, 1 random gaps
  int        hold_cycles = 0;   // long receiver hold-off requested by a test

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // clamped sizes and output plane for the current registers
  function automatic void update_geom();
    g_d  = clampi(int'(r_depth), 1, MaxInCh);
    g_h  = clampi(int'(r_height), 1, MaxDim);
    g_w  = clampi(int'(r_width), 1, MaxDim);
    g_k  = clampi(int'(r_ksize), 1, MaxK);
    g_o  = clampi(int'(r_odepth), 1, MaxOutCh);
    g_oh = (g_h >= g_k) ? g_h - g_k + 1 : 0;
    g_ow = (g_w >= g_k) ? g_w - g_k + 1 : 0;
    n_out = g_o * g_oh * g_ow;
  endfunction

  function automatic int store_size(req_e req);
    case (req)
      REQ_SAMPLE: return clampi(g_d * g_h * g_w, 0, SampleDepth);
      REQ_WEIGHT: return clampi(g_o * g_d * g_k * g_k, 0, WeightDepth);
      default:    return clampi(n_out, 0, BiasDepth);
    endcase
  endfunction

  // one item through the layer: store update or convolution result
  function automatic void predict_item(req_e req, logic [IdxW-1:0] idx,
                                       logic signed [ValW-1:0] v);
    conv_res_t res;
    longint    acc;
    int        o, rr, cc, rem, si, wi;
    res.idx = idx;
    res.val = '0;
    res.st  = ST_RANGE;
    if (idx >= store_size(req)) begin
      pending_res.push_back(res);
      return;
    end
    case (req)
      REQ_SAMPLE: begin sample_mem[idx] = v; sample_wr[idx] = 1'b1; end
      REQ_WEIGHT: begin weight_mem[idx] = v; weight_wr[idx] = 1'b1; end
      REQ_BIAS:   begin bias_mem[idx] = v; bias_wr[idx] = 1'b1; end
      default: begin
        o   = idx / (g_oh * g_ow);
        rem = idx % (g_oh * g_ow);
        rr  = rem / g_ow;
        cc  = rem % g_ow;
        acc = longint'(bias_mem[idx]) * 4096;
        for (int d = 0; d < g_d; d++)
          for (int i = 0; i < g_k; i++)
            for (int j = 0; j < g_k; j++) begin
              si = (d * g_h + rr + i) * g_w + cc + j;
              wi = ((o * g_d + d) * g_k + i) * g_k + j;
              acc += longint'(sample_mem[si]) * longint'(weight_mem[wi]);
            end
        acc = (acc + 2048) >>> 12;  // round half up to Q4.12
        res.st = ST_OK;
        if (acc > 32767) begin acc = 32767; res.st = ST_SAT; end
        if (acc < -32768) begin acc = -32768; res.st = ST_SAT; end
        res.val = acc[ValW-1:0];
        pending_res.push_back(res);
      end
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] pick_val(vsel_e sel);
    case (sel)
      V_MAX:  return 16'sh7fff;
      V_MIN:  return 16'sh8000;
      V_ZERO: return '0;
      default: begin
        if ($urandom_range(0, 3) == 0) return ValW'($urandom());
        return ValW'($urandom_range(0, 2047) - 1024);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    if (gap_mode == 0 || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) != 0) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // sender: caller stands at a rising edge; returns at the accepting edge
  task automatic send_item(req_e req, logic [IdxW-1:0] idx, logic signed [ValW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, v, idx};
    s_axis_tuser_i  <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_item(req, idx, v);
  endtask

  // idle point: all results in, then let a trailing load finish
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] dv, logic [7:0] hv, logic [7:0] wv,
                            logic [7:0] kv, logic [7:0] ov);
    logic [7:0] vals [5];
    vals = '{dv, hv, wv, kv, ov};
    for (int a = 0; a < 5; a++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= cfg_e'(a);
      cfg_data_i  <= vals[a];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (cfg_e'(a))
        CFG_IN_DEPTH:  r_depth  = vals[a][2:0];
        CFG_IN_HEIGHT: r_height = vals[a][5:0];
        CFG_IN_WIDTH:  r_width  = vals[a][5:0];
        CFG_KSIZE:     r_ksize  = vals[a][2:0];
        default:       r_odepth = vals[a][3:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
    update_geom();
    @(posedge clk_i);
  endtask

  // make sure every operand of output idx holds data (or overwrite them all)
  task automatic load_operands(int idx, bit overwrite, vsel_e ssel, vsel_e wsel, vsel_e bsel);
    int o, rem, rr, cc, si, wi;
    o   = idx / (g_oh * g_ow);
    rem = idx % (g_oh * g_ow);
    rr  = rem / g_ow;
    cc  = rem % g_ow;
    for (int d = 0; d < g_d; d++)
      for (int i = 0; i < g_k; i++)
        for (int j = 0; j < g_k; j++) begin
          si = (d * g_h + rr + i) * g_w + cc + j;
          wi = ((o * g_d + d) * g_k + i) * g_k + j;
          if (overwrite || !sample_wr[si]) send_item(REQ_SAMPLE, IdxW'(si), pick_val(ssel));
          if (overwrite || !weight_wr[wi]) send_item(REQ_WEIGHT, IdxW'(wi), pick_val(wsel));
        end
    if (overwrite || !bias_wr[idx]) send_item(REQ_BIAS, IdxW'(idx), pick_val(bsel));
  endtask

  // mostly valid computes with their operands loaded, some loads, some out-of-range noise
  task automatic random_items(int n);
    int   roll, sz, idx;
    req_e req;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) gap_mode = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      req  = req_e'($urandom_range(0, 3));
      if (roll < 55 && n_out > 0) begin
        idx = $urandom_range(0, n_out - 1);
        load_operands(idx, 1'b0, V_RAND, V_RAND, V_RAND);
        send_item(REQ_COMPUTE, IdxW'(idx), ValW'($urandom()));
      end else if (roll < 85 && req != REQ_COMPUTE && store_size(req) > 0) begin
        send_item(req, IdxW'($urandom_range(0, store_size(req) - 1)), pick_val(V_RAND));
      end else begin
        sz = store_size(req);
        if (sz < 8192) send_item(req, IdxW'($urandom_range(sz, 8191)), ValW'($urandom()));
      end
    end
  endtask

  // default registers: saturation both ways, zero result, every range error
  task automatic test_directed();
    load_operands(0, 1'b1, V_MAX, V_MAX, V_MAX);
    send_item(REQ_COMPUTE, 13'd0, 16'sh7fff);
    load_operands(0, 1'b1, V_MAX, V_MIN, V_MIN);
    send_item(REQ_COMPUTE, 13'd0, 16'sh8000);
    load_operands(899, 1'b1, V_ZERO, V_RAND, V_ZERO);
    send_item(REQ_COMPUTE, 13'd899, '0);
    send_item(REQ_SAMPLE, 13'd1024, 16'sh7fff);
    send_item(REQ_SAMPLE, 13'd8191, 16'sh8000);
    send_item(REQ_WEIGHT, 13'd9, 16'sh1234);
    send_item(REQ_BIAS, 13'd900, -16'sd1);
    send_item(REQ_COMPUTE, 13'd900, '0);
    send_item(REQ_COMPUTE, 13'd8191, -16'sd1);
    drain();
  endtask

  task automatic test_small_layer();
    set_config(8'd2, 8'd6, 8'd5, 8'd3, 8'd2);
    random_items(250);
    drain();
  endtask

  // zero in every register: all clamp to the lower bound, a 1x1 layer
  task automatic test_clamp_low();
    set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_items(100);
    drain();
  endtask

  // upper bits set: height, kernel and filters clamp high, then depth with a 1x1 kernel
  task automatic test_clamp_high();
    set_config(8'd1, 8'hff, 8'd6, 8'hff, 8'hff);
    random_items(80);
    drain();
    set_config(8'hff, 8'd32, 8'd32, 8'd1, 8'hff);
    random_items(60);
    drain();
  endtask

  // kernel taller than the input plane: no valid output index exists
  task automatic test_kernel_too_big();
    set_config(8'd2, 8'd3, 8'd8, 8'd5, 8'd3);
    random_items(100);
    drain();
  endtask

  // receiver holds off while computes keep coming, so the input stalls
  task automatic test_backpressure();
    int idxs [24];
    set_config(8'd4, 8'd7, 8'd7, 8'd5, 8'd3);
    gap_mode = 0;
    foreach (idxs[i]) begin
      idxs[i] = $urandom_range(0, n_out - 1);
      load_operands(idxs[i], 1'b0, V_RAND, V_RAND, V_RAND);
    end
    hold_cycles = 1500;
    foreach (idxs[i]) send_item(REQ_COMPUTE, IdxW'(idxs[i]), ValW'($urandom()));
    random_items(200);
    drain();
  endtask

  initial begin
    update_geom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_small_layer();
    test_clamp_low();
    test_clamp_high();
    test_kernel_too_big();
    test_backpressure();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: random stalls in stretches, plus the long hold-off on request
  initial begin
    int rx_mode;
    rx_mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      if ($urandom_range(0, 255) == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 9) < 7);
        default: m_axis_tready_i <= ($urandom_range(0, 99) != 0) ? ($urandom_range(0, 3) != 0)
                                                                 : 1'b0;
      endcase
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    conv_res_t exp_r;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected item idx=%0d val=%0d st=%0d", $realtime,
                 m_axis_tdata_o[12:0], $signed(m_axis_tdata_o[28:13]), m_axis_tuser_o);
        errors++;
      end else begin
        exp_r = pending_res.pop_front();
        if (m_axis_tdata_o[12:0] !== exp_r.idx) begin
          $display("%0t: out_index expected %0d got %0d", $realtime, exp_r.idx,
                   m_axis_tdata_o[12:0]);
          errors++;
        end
        if (m_axis_tdata_o[28:13] !== exp_r.val) begin
          $display("%0t: out_value (idx %0d) expected %0d got %0d", $realtime, exp_r.idx,
                   exp_r.val, $signed(m_axis_tdata_o[28:13]));
          errors++;
        end
        if (m_axis_tuser_o !== exp_r.st) begin
          $display("%0t: status (idx %0d) expected %0d got %0d", $realtime, exp_r.idx,
                   exp_r.st, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

endmodule
